/* hw/rtl/p1305_pkg.sv */
// Shared types, constants and the product-scanning schedule for the Poly1305 core.
// Used by p1305_mac_unit and poly1305_authenticator_core; depends on nothing else.
package p1305_pkg;

	// Register indexes of the configuration port.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_R_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_S_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_S_HIGH = 3'd3;

	// Clamp masks for the two halves of r.
	localparam logic [63:0] CLAMP_LOW  = 64'h0fff_fffc_0fff_ffff;
	localparam logic [63:0] CLAMP_HIGH = 64'h0fff_fffc_0fff_fffc;

	// Field widths on the stream channels.
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 128;

	// Multiply schedule: 5 words of h times 4 words of r, 20 products.
	localparam int NUM_STEPS = 20;
	localparam int STEP_W    = 5;

	// Modulus 2^130 - 5.
	localparam logic [129:0] MODULUS = {2'b11, {125{1'b1}}, 3'b011};

	typedef struct packed {
		logic [2:0] h_idx;
		logic [1:0] r_idx;
		logic       col_end;
	} pair_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic       clr;
		logic       valid;
		logic       col_end;
		logic [2:0] col_idx;
	} mac_ctrl_t;

	// Products ordered by output column; col_end flags the last product of a column.
	function automatic pair_t step_pair(input logic [STEP_W-1:0] step);
		pair_t p;
		p = '0;
		unique case (step)
			5'd0:  p = '{3'd0, 2'd0, 1'b1};
			5'd1:  p = '{3'd0, 2'd1, 1'b0};
			5'd2:  p = '{3'd1, 2'd0, 1'b1};
			5'd3:  p = '{3'd0, 2'd2, 1'b0};
			5'd4:  p = '{3'd1, 2'd1, 1'b0};
			5'd5:  p = '{3'd2, 2'd0, 1'b1};
			5'd6:  p = '{3'd0, 2'd3, 1'b0};
			5'd7:  p = '{3'd1, 2'd2, 1'b0};
			5'd8:  p = '{3'd2, 2'd1, 1'b0};
			5'd9:  p = '{3'd3, 2'd0, 1'b1};
			5'd10: p = '{3'd1, 2'd3, 1'b0};
			5'd11: p = '{3'd2, 2'd2, 1'b0};
			5'd12: p = '{3'd3, 2'd1, 1'b0};
			5'd13: p = '{3'd4, 2'd0, 1'b1};
			5'd14: p = '{3'd2, 2'd3, 1'b0};
			5'd15: p = '{3'd3, 2'd2, 1'b0};
			5'd16: p = '{3'd4, 2'd1, 1'b1};
			5'd17: p = '{3'd3, 2'd3, 1'b0};
			5'd18: p = '{3'd4, 2'd2, 1'b1};
			5'd19: p = '{3'd4, 2'd3, 1'b1};
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

/* hw/rtl/p1305_mac_unit.sv */
// Shared 32x32 multiplier with a column accumulator for product scanning.
// Depends on p1305_pkg for the control struct.
module p1305_mac_unit import p1305_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  mac_ctrl_t     ctrl,
	input  logic [31:0]   op_a,
	input  logic [31:0]   op_b,
	output logic [255:0]  prod
);

	logic [63:0]  mult_s1;
	mac_ctrl_t    ctrl_s1;
	logic [67:0]  col_q;
	logic [255:0] prod_q;
	logic [67:0]  col_sum;

	// Column sum: running carry plus the registered product.
	assign col_sum = col_q + {4'b0, mult_s1};
	assign prod    = prod_q;

	// Multiplier stage, registered before accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		mult_s1 <= op_a * op_b;
	end

	// Accumulate a column; at its end emit one result word and keep the carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.clr) begin
			col_q <= '0;
		end else if (ctrl_s1.valid) begin
			if (ctrl_s1.col_end) begin
				col_q <= {32'b0, col_sum[67:32]};
			end else begin
				col_q <= col_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.valid && ctrl_s1.col_end) begin
			prod_q[ctrl_s1.col_idx*32 +: 32] <= col_sum[31:0];
		end
	end

endmodule

/* hw/rtl/poly1305_authenticator_core.sv */
// Poly1305 one-time authenticator: top level with sequencer, reduction and tag output.
// Depends on p1305_pkg and p1305_mac_unit.
//
// Usage: write the 256-bit key through cfg_we/cfg_index/cfg_data (index 0..3 for
// r low, r high, s low, s high); every write to a valid index clears the
// accumulator. Configure only while the core is idle.
// Input: one 16-byte block per s_* transfer; s_tlast marks the final block of a
// message. Output: one 128-bit tag per message on m_*, after the final block.
// Sequence: a block with a nonzero byte count passes from acceptance through ST_MUL
// (the products on the shared 32x32 multiplier), ST_DRAIN, ST_RED1, ST_RED2, ST_RED3
// and ST_FIN before s_tready is high again. A block with zero count goes from
// acceptance straight to ST_FIN. The tag appears in the cycle after the finish cycle.
// The tag sits in an output register; a stalled receiver only holds the core in
// its finish cycle when the next tag is ready while the previous one is unread.
// Reset clears key, accumulator and output valid; no memory sweep is needed.
module poly1305_authenticator_core import p1305_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]            cfg_data,
	// Block input. tdata: block_low[63:0], block_high[127:64], block_bytes[132:128].
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	// Tag output. tdata: tag_low[63:0], tag_high[127:64].
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_RED1,
		ST_RED2,
		ST_RED3,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              last_q;
	logic [127:0]      r_q;
	logic [127:0]      s_q;
	logic [129:0]      acc_q;
	logic [130:0]      h_q;
	logic [130:0]      red_q;
	logic [127:0]      tag_q;
	logic              tag_valid_q;

	logic              accept;
	logic [127:0]      blk;
	logic [4:0]        blk_bytes;
	logic [127:0]      pad_bit;
	logic [128:0]      msg;
	logic [130:0]      h_next;
	pair_t             pair;
	mac_ctrl_t         mac_ctrl;
	logic [31:0]       op_a;
	logic [31:0]       op_b;
	logic [255:0]      prod;
	logic [125:0]      prod_hi;
	logic [130:0]      fold1;
	logic [130:0]      fold2;
	logic [130:0]      minus_p;
	logic              tag_slot_free;
	logic              cfg_hit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = tag_valid_q;
	assign m_tdata  = tag_q;

	// Message padding: full blocks get bit 128, short ones a 0x01 byte after the data.
	assign blk       = s_tdata[127:0];
	assign blk_bytes = s_tdata[132:128];
	assign pad_bit   = 128'b1 << {blk_bytes[3:0], 3'b000};
	assign msg       = blk_bytes[4] ? {1'b1, blk} : {1'b0, (blk & (pad_bit - 128'b1)) | pad_bit};
	assign h_next    = {1'b0, acc_q} + {2'b0, msg};

	// Operand selection for the shared multiplier.
	assign pair = step_pair(step_q);
	always_comb begin
		unique case (pair.h_idx)
			3'd0:    op_a = h_q[31:0];
			3'd1:    op_a = h_q[63:32];
			3'd2:    op_a = h_q[95:64];
			3'd3:    op_a = h_q[127:96];
			3'd4:    op_a = {29'b0, h_q[130:128]};
			default: op_a = '0;
		endcase
	end
	assign op_b = r_q[pair.r_idx*32 +: 32];

	assign mac_ctrl.clr     = accept;
	assign mac_ctrl.valid   = (state_q == ST_MUL);
	assign mac_ctrl.col_end = pair.col_end;
	assign mac_ctrl.col_idx = pair.h_idx + {1'b0, pair.r_idx};

	p1305_mac_unit u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod   (prod)
	);

	// Reduction modulo 2^130-5: fold the high part times five, fold again, subtract once.
	assign prod_hi = prod[255:130];
	assign fold1   = {1'b0, prod[129:0]} + {3'b0, prod_hi, 2'b0} + {5'b0, prod_hi};
	assign fold2   = {1'b0, red_q[129:0]} + (red_q[130] ? 131'd5 : 131'd0);
	assign minus_p = red_q + 131'd5;

	assign tag_slot_free = !tag_valid_q || m_tready;
	assign cfg_hit = cfg_we && (cfg_index == REG_KEY_R_LOW || cfg_index == REG_KEY_R_HIGH
		|| cfg_index == REG_KEY_S_LOW || cfg_index == REG_KEY_S_HIGH);

	// Sequencer, key registers, accumulator and tag register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			last_q      <= 1'b0;
			r_q         <= '0;
			s_q         <= '0;
			acc_q       <= '0;
			h_q         <= '0;
			red_q       <= '0;
			tag_q       <= '0;
			tag_valid_q <= 1'b0;
		end else begin
			if (tag_valid_q && m_tready) begin
				tag_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						step_q <= '0;
						h_q    <= h_next;
						if (blk_bytes == 5'd0) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (step_q == STEP_W'(NUM_STEPS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RED1;
				end
				ST_RED1: begin
					red_q   <= fold1;
					state_q <= ST_RED2;
				end
				ST_RED2: begin
					red_q   <= fold2;
					state_q <= ST_RED3;
				end
				ST_RED3: begin
					acc_q   <= minus_p[130] ? minus_p[129:0] : red_q[129:0];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (tag_slot_free) begin
						tag_q       <= acc_q[127:0] + s_q;
						tag_valid_q <= 1'b1;
						acc_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Key writes take effect last and always clear the accumulator.
			if (cfg_hit) begin
				acc_q <= '0;
				unique case (cfg_index)
					REG_KEY_R_LOW:  r_q[63:0]   <= cfg_data & CLAMP_LOW;
					REG_KEY_R_HIGH: r_q[127:64] <= cfg_data & CLAMP_HIGH;
					REG_KEY_S_LOW:  s_q[63:0]   <= cfg_data;
					REG_KEY_S_HIGH: s_q[127:64] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// The accumulator is always fully reduced.
	assert property (@(posedge clk) disable iff (!arst_n) acc_q < MODULUS)
		else $error("accumulator not fully reduced");

	// The multiply step counter stays inside the schedule.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> step_q < STEP_W'(NUM_STEPS))
		else $error("multiply step out of range");

	// Emitting a tag clears the accumulator.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && last_q && tag_slot_free |=> acc_q == '0 && tag_valid_q)
		else $error("tag emitted without clearing accumulator");

	// A key write clears the accumulator.
	assert property (@(posedge clk) disable iff (!arst_n) cfg_hit |=> acc_q == '0)
		else $error("key write did not clear accumulator");
`endif

endmodule

/* tb/poly1305_tag_checker.sv */
// Tag checker for poly1305_authenticator_core: watches the key port and both streams,
// keeps its own Poly1305 accumulator and key, and compares every tag with its prediction.
// Depends on p1305_pkg for the register indexes and the stream widths.
module poly1305_tag_checker import p1305_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     errors,
	output int                     tags_pending,
	output int                     blocks_taken,
	output int                     tags_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} tag_t;

	localparam logic [63:0]  R_KEEP_LOW  = 64'h0fff_fffc_0fff_ffff;
	localparam logic [63:0]  R_KEEP_HIGH = 64'h0fff_fffc_0fff_fffc;
	localparam logic [130:0] PRIME       = (131'd1 << 130) - 131'd5;
	localparam int           FULL_BLOCK  = 16;

	logic [63:0]  r_lo = '0;
	logic [63:0]  r_hi = '0;
	logic [63:0]  s_lo = '0;
	logic [63:0]  s_hi = '0;
	logic [129:0] poly_acc = '0;
	tag_t         pending_tags[$];

	initial begin
		errors = 0;
		tags_pending = 0;
		blocks_taken = 0;
		tags_seen = 0;
	end

	// Extend a message block: a full block gets bit 128, a short one a 0x01 byte after its data.
	function automatic logic [128:0] pad_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] nbytes);
		logic [127:0] mask;
		if (nbytes >= FULL_BLOCK)
			return {1'b1, hi, lo};
		mask = (128'd1 << {nbytes, 3'b000}) - 128'd1;
		return {1'b0, ({hi, lo} & mask) | (128'd1 << {nbytes, 3'b000})};
	endfunction

	// Compute (acc + m) * r modulo 2^130 - 5, fully reduced.
	function automatic logic [129:0] mul_mod_p(input logic [129:0] acc, input logic [128:0] m,
			input logic [127:0] r);
		logic [130:0] h;
		logic [259:0] x;
		h = {1'b0, acc} + {2'b00, m};
		x = {129'd0, h} * {132'd0, r};
		// Fold everything above bit 130 back in as times five.
		while (x[259:130] != '0)
			x = {130'd0, x[129:0]} + {130'd0, x[259:130]} * 260'd5;
		if (x >= {129'd0, PRIME})
			x = x - {129'd0, PRIME};
		return x[129:0];
	endfunction

	// Track the key, absorb accepted blocks and check every tag transfer.
	always @(posedge clk or negedge arst_n) begin : watch
		tag_t       got;
		tag_t       want;
		logic [4:0] nbytes;
		if (!arst_n) begin
			r_lo = '0;
			r_hi = '0;
			s_lo = '0;
			s_hi = '0;
			poly_acc = '0;
			pending_tags.delete();
			tags_pending = 0;
		end else begin
			// A write to a key register also clears the accumulator; spare indexes do nothing.
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_R_LOW: begin
						r_lo = cfg_data;
						poly_acc = '0;
					end
					REG_KEY_R_HIGH: begin
						r_hi = cfg_data;
						poly_acc = '0;
					end
					REG_KEY_S_LOW: begin
						s_lo = cfg_data;
						poly_acc = '0;
					end
					REG_KEY_S_HIGH: begin
						s_hi = cfg_data;
						poly_acc = '0;
					end
					default: ;
				endcase
			end

			// Output side first, so a tag is never matched against one queued at the same edge.
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				tags_seen++;
				if (pending_tags.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] tag with none expected: low %h high %h",
							$realtime, got.lo, got.hi);
				end else begin
					want = pending_tags.pop_front();
					if (got.lo != want.lo || got.hi != want.hi) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] tag mismatch: expected low %h high %h, got low %h high %h",
								$realtime, want.lo, want.hi, got.lo, got.hi);
					end
				end
			end

			if (s_tvalid && s_tready) begin
				nbytes = s_tdata[132:128];
				blocks_taken++;
				if (nbytes != 5'd0)
					poly_acc = mul_mod_p(poly_acc, pad_block(s_tdata[63:0], s_tdata[127:64], nbytes),
						{r_hi & R_KEEP_HIGH, r_lo & R_KEEP_LOW});
				if (s_tlast) begin
					want = poly_acc[127:0] + {s_hi, s_lo};
					pending_tags.push_back(want);
					poly_acc = '0;
				end
			end
			tags_pending = pending_tags.size();
		end
	end

endmodule

/* tb/tb_poly1305_authenticator_core.sv */
// Testbench top for poly1305_authenticator_core: clock, reset, key writes and block stimulus.
// Depends on p1305_pkg, the core itself and poly1305_tag_checker, which judges every tag.
module tb_poly1305_authenticator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import p1305_pkg::*;

	localparam int FULL_BLOCK    = 16;
	localparam int RANDOM_ITEMS  = 900;
	localparam int PHASE_ITEMS   = 150;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;
	// Indexes past the key registers; writes there must leave the core alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
	localparam int NUM_SPARE = 4;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [63:0]            cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int errors;
	int tags_pending;
	int blocks_taken;
	int tags_seen;
	int burst_left = 0;
	int items_sent = 0;
	int key_settings = 1;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	poly1305_authenticator_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	poly1305_tag_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.errors       (errors),
		.tags_pending (tags_pending),
		.blocks_taken (blocks_taken),
		.tags_seen    (tags_seen)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Tag receiver: switches between always ready, coin flips, a fixed beat and long stalls.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 400);
		end else begin
			rx_left--;
		end
		rx_tick++;
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (rx_tick % 5 == 0);
			default:     m_tready <= ($urandom_range(0, 29) == 0);
		endcase
	end

	// Random 64-bit word, now and then one of the extremes.
	function automatic logic [63:0] draw_word();
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0)
			return '1;
		if (pick == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Offer one block and hold it until the core takes it; gaps come between bursts.
	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [4:0] nbytes, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, nbytes, hi, lo};
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (nbytes != 5'd0 || is_last)
			items_sent++;
	endtask

	// Stop sending, wait for every owed tag, then let a tagless block finish too.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (tags_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four key registers back to back.
	task automatic program_key(input logic [63:0] rl, input logic [63:0] rh,
			input logic [63:0] sl, input logic [63:0] sh);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KEY_R_LOW;
		cfg_data  <= rl;
		@(posedge clk);
		cfg_index <= REG_KEY_R_HIGH;
		cfg_data  <= rh;
		@(posedge clk);
		cfg_index <= REG_KEY_S_LOW;
		cfg_data  <= sl;
		@(posedge clk);
		cfg_index <= REG_KEY_S_HIGH;
		cfg_data  <= sh;
		@(posedge clk);
		cfg_we <= 1'b0;
		key_settings++;
	endtask

	// Write random data to every spare index; the accumulator must survive.
	task automatic write_spare();
		for (int i = 0; i < NUM_SPARE; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_SPARE_FIRST + CFG_IDX_W'(i);
			cfg_data  <= draw_word();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// A well-formed message: full blocks, then a final block of 1 to 16 bytes.
	task automatic send_message();
		int           nblk;
		logic [4:0]   tail;
		logic [127:0] data;
		nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
		for (int i = 0; i < nblk - 1; i++)
			send_block(draw_word(), draw_word(), 5'(FULL_BLOCK), 1'b0);
		tail = ($urandom_range(0, 1) == 1) ? 5'(FULL_BLOCK) : 5'($urandom_range(1, 15));
		data = {draw_word(), draw_word()};
		// Half of the short blocks carry junk above their byte count.
		if (tail < FULL_BLOCK && $urandom_range(0, 1) == 1)
			data = data & ((128'd1 << {tail, 3'b000}) - 128'd1);
		send_block(data[63:0], data[127:64], tail, 1'b1);
	endtask

	// Odd items: empty blocks, oversized counts, short blocks in mid-message.
	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_block(draw_word(), draw_word(), 5'd0, 1'($urandom_range(0, 1)));
			1: send_block(draw_word(), draw_word(), 5'($urandom_range(17, 31)),
				1'($urandom_range(0, 1)));
			2: send_block(draw_word(), draw_word(), 5'($urandom_range(1, 15)), 1'b0);
			default: send_block(draw_word(), draw_word(), 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)));
		endcase
	endtask

	// Give up if the run hangs.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d tags outstanding", cycles, tags_pending);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [63:0] ones;
		int          random_start;
		int          phase_left;
		int          kind;
		ones      = '1;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Key from reset is all zero: the empty message and a full block both give zero.
		send_block(draw_word(), draw_word(), 5'd0, 1'b1);
		send_block(ones, ones, 5'(FULL_BLOCK), 1'b1);
		drain();

		// All-ones key: every clamp bit and the largest pad.
		program_key(ones, ones, ones, ones);
		send_block(ones, ones, 5'(FULL_BLOCK), 1'b0);
		send_block(ones, ones, 5'(FULL_BLOCK), 1'b1);
		send_block(draw_word(), draw_word(), 5'd0, 1'b1);
		send_block(ones, ones, 5'd1, 1'b1);
		send_block(draw_word(), draw_word(), 5'd7, 1'b1);
		send_block(draw_word(), draw_word(), 5'd8, 1'b1);
		send_block(draw_word(), draw_word(), 5'd9, 1'b1);
		send_block(draw_word(), draw_word(), 5'd15, 1'b1);
		send_block(draw_word(), draw_word(), 5'd17, 1'b1);
		send_block(draw_word(), draw_word(), 5'd31, 1'b0);
		send_block(draw_word(), draw_word(), 5'd5, 1'b0);
		send_block(draw_word(), draw_word(), 5'd0, 1'b0);
		send_block('0, '0, 5'(FULL_BLOCK), 1'b1);
		drain();

		// With r = 1 these three blocks sum to exactly 2^130 - 5, which must reduce to zero.
		program_key(64'd1, '0, draw_word(), draw_word());
		send_block(64'hffff_ffff_ffff_fffb, ones, 5'(FULL_BLOCK), 1'b0);
		send_block('0, '0, 5'(FULL_BLOCK), 1'b0);
		send_block('0, '0, 5'(FULL_BLOCK), 1'b1);

		// Spare-index writes in mid-message keep the accumulator.
		send_block(draw_word(), draw_word(), 5'(FULL_BLOCK), 1'b0);
		drain();
		write_spare();
		send_block(draw_word(), draw_word(), 5'd3, 1'b1);

		// A key write in mid-message clears it.
		send_block(draw_word(), draw_word(), 5'(FULL_BLOCK), 1'b0);

		// Random part: mostly proper messages, changing the key every phase.
		random_start = items_sent;
		phase_left = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			if (phase_left <= 0) begin
				drain();
				kind = $urandom_range(0, 5);
				if (kind == 0)
					program_key(ones, ones, ones, ones);
				else if (kind == 1)
					program_key('0, '0, draw_word(), draw_word());
				else
					program_key(draw_word(), draw_word(), draw_word(), draw_word());
				if ($urandom_range(0, 2) == 0)
					write_spare();
				phase_left = PHASE_ITEMS;
			end
			kind = items_sent;
			if ($urandom_range(0, 99) < 85)
				send_message();
			else
				send_noise();
			phase_left -= items_sent - kind;
			if ($urandom_range(0, 39) == 0)
				drain();
		end
		drain();

		$display("Sent %0d blocks under %0d key settings; %0d tags compared, %0d mismatches.",
			blocks_taken, key_settings, tags_seen, errors);
		if (errors == 0 && tags_pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
